@@ rtl/assert_macros.svh @@
// Assertion macros used by the frame receiver core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/wsfr_pkg.sv @@
// Package with types and constants of the WebSocket frame receiver.
package wsfr_pkg;

  localparam int unsigned LimitBitsDefault = 16;
  localparam int unsigned CfgWidth         = 16;

  localparam logic [CfgWidth-1:0] BufferLimitReset = 16'd4096;

  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  localparam logic [2:0] Ext16BytesM1 = 3'd1;
  localparam logic [2:0] Ext64BytesM1 = 3'd7;
  localparam logic [2:0] KeyBytesM1   = 3'd3;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrRsv  = 2'd1;
  localparam logic [1:0] ErrFrag = 2'd2;

  typedef enum logic [5:0] {
    PhHdr0    = 6'b000001,
    PhHdr1    = 6'b000010,
    PhExtLen  = 6'b000100,
    PhKey     = 6'b001000,
    PhPayload = 6'b010000,
    PhFailed  = 6'b100000
  } phase_e;

endpackage

@@ rtl/websocket_frame_receiver_core.sv @@
// Top level of the WebSocket frame receiver: header parser and payload delivery.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) carries link bytes, one
//   per transfer. Output channel (out_valid_o / out_stall_i) carries results:
//   data_byte_o, hdr_opcode_o, data_valid_o, last_of_frame_o, error_code_o.
//   cfg_we_i writes cfg_wdata_i into buffer_limit, the most payload bytes
//   delivered per frame; write it only while the block is idle.
//   Each byte is parsed in the cycle it is accepted; a result it causes is
//   presented from the next cycle on.
//   Throughput is one byte per cycle while the output is not stalled, set by
//   the single parse step between the input handshake and the output register.
//   The input is stalled only while a result is held and out_stall_i is
//   high; once the result is taken the next byte is accepted in that cycle.
//   Reset clears the parser to expect the first header byte, sets
//   buffer_limit to 4096 and empties the output register.
//   After a reserved-bit or fragmentation error the block drops every byte
//   until reset.
`include "assert_macros.svh"

module websocket_frame_receiver_core #(
  parameter int unsigned LIMIT_BITS = wsfr_pkg::LimitBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsfr_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    data_byte_o,
  output logic [3:0]                    hdr_opcode_o,
  output logic                          data_valid_o,
  output logic                          last_of_frame_o,
  output logic [1:0]                    error_code_o
);
  import wsfr_pkg::*;

  localparam int unsigned CommonW = (LIMIT_BITS < CfgWidth) ? LIMIT_BITS : CfgWidth;

  phase_e                phase_q, phase_d;
  logic [2:0]            count_q, count_d;
  logic [63:0]           left_q, left_d;
  logic [LIMIT_BITS-1:0] dlv_q, dlv_d;
  logic [3:0]            opcode_q, opcode_d;
  logic                  fin_q, fin_d;
  logic                  mask_q, mask_d;
  logic [CfgWidth-1:0]   limit_q;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_data_q;
  logic [3:0]            out_opcode_q;
  logic                  out_dvalid_q;
  logic                  out_last_q;
  logic [1:0]            out_err_q;

  logic                  fire_in;
  logic                  out_take;
  logic [LIMIT_BITS-1:0] lim;
  logic                  emit;
  logic [7:0]            res_data;
  logic                  res_valid;
  logic                  res_last;
  logic [1:0]            res_err;
  logic                  len_done;
  logic                  start;
  logic [63:0]           start_len;
  logic [63:0]           left_dec;
  logic [LIMIT_BITS-1:0] dlv_inc;

  assign lim      = LIMIT_BITS'(limit_q[CommonW-1:0]);
  assign out_take = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire_in  = in_valid_i && !in_stall_o;
  assign left_dec = (left_q != 64'd0) ? (left_q - 64'd1) : left_q;
  assign dlv_inc  = dlv_q + LIMIT_BITS'(1);

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    left_d    = left_q;
    dlv_d     = dlv_q;
    opcode_d  = opcode_q;
    fin_d     = fin_q;
    mask_d    = mask_q;
    emit      = 1'b0;
    res_data  = 8'd0;
    res_valid = 1'b0;
    res_last  = 1'b0;
    res_err   = ErrNone;
    len_done  = 1'b0;
    start     = 1'b0;
    start_len = left_q;
    if (fire_in) begin
      unique case (phase_q)
        PhHdr0: begin
          opcode_d = rx_byte_i[3:0];
          fin_d    = rx_byte_i[7];
          if (rx_byte_i[6:4] != 3'd0) begin
            phase_d = PhFailed;
            emit    = 1'b1;
            res_err = ErrRsv;
          end else begin
            phase_d = PhHdr1;
          end
        end
        PhHdr1: begin
          mask_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == LenExt16) begin
            phase_d = PhExtLen;
            count_d = Ext16BytesM1;
            left_d  = 64'd0;
          end else if (rx_byte_i[6:0] == LenExt64) begin
            phase_d = PhExtLen;
            count_d = Ext64BytesM1;
            left_d  = 64'd0;
          end else begin
            left_d   = {57'd0, rx_byte_i[6:0]};
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          left_d = {left_q[55:0], rx_byte_i};
          if (count_q == 3'd0) begin
            len_done = 1'b1;
          end else begin
            count_d = count_q - 3'd1;
          end
        end
        PhKey: begin
          if (count_q == 3'd0) begin
            start = 1'b1;
          end else begin
            count_d = count_q - 3'd1;
          end
        end
        PhPayload: begin
          left_d = left_dec;
          if (left_dec == 64'd0) begin
            phase_d = PhHdr0;
          end
          if (dlv_q < lim) begin
            dlv_d     = dlv_inc;
            emit      = 1'b1;
            res_data  = rx_byte_i;
            res_valid = 1'b1;
            res_last  = (left_dec == 64'd0) || (dlv_inc >= lim);
          end
        end
        PhFailed: begin
          phase_d = PhFailed;
        end
        default: begin
          phase_d = PhFailed;
        end
      endcase

      if (len_done) begin
        if (!fin_q) begin
          phase_d = PhFailed;
          emit    = 1'b1;
          res_err = ErrFrag;
        end else if (mask_d) begin
          phase_d = PhKey;
          count_d = KeyBytesM1;
        end else begin
          start = 1'b1;
        end
        start_len = left_d;
      end

      if (start) begin
        dlv_d = '0;
        if (start_len == 64'd0) begin
          phase_d  = PhHdr0;
          emit     = 1'b1;
          res_last = 1'b1;
        end else begin
          phase_d = PhPayload;
          if (lim == '0) begin
            emit     = 1'b1;
            res_last = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (fire_in && emit) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      count_q     <= 3'd0;
      left_q      <= 64'd0;
      dlv_q       <= '0;
      opcode_q    <= 4'd0;
      fin_q       <= 1'b0;
      mask_q      <= 1'b0;
      limit_q     <= BufferLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      left_q      <= left_d;
      dlv_q       <= dlv_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_in && emit) begin
      out_data_q   <= res_data;
      out_opcode_q <= opcode_d;
      out_dvalid_q <= res_valid;
      out_last_q   <= res_last;
      out_err_q    <= res_err;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = out_data_q;
  assign hdr_opcode_o    = out_opcode_q;
  assign data_valid_o    = out_dvalid_q;
  assign last_of_frame_o = out_last_q;
  assign error_code_o    = out_err_q;

  `ASSERT_RST(a_failed_sticks, clk_i, rst_ni, (phase_q == PhFailed) |=> (phase_q == PhFailed))
  `ASSERT_ALWAYS(a_stall_needs_result, clk_i, in_stall_o |-> out_valid_o)
  `ASSERT_RST(a_empty_has_no_data, clk_i, rst_ni,
    (out_valid_o && !data_valid_o) |-> (data_byte_o == 8'd0))
  `ASSERT_RST(a_error_unmarked, clk_i, rst_ni,
    (out_valid_o && (error_code_o != ErrNone)) |-> (!data_valid_o && !last_of_frame_o))

endmodule
